### rtl/ccg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccg_pkg: shared types and constants of the charset combination generator
// Request and command codes, register indexes, filter modes and field widths.
// ----------------------------------------------------------------------------
package ccg_pkg;

  localparam int MAX_CHARS_DEF  = 64;
  localparam int MAX_LENGTH_DEF = 8;

  localparam int REQ_W      = 2;
  localparam int IDX_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int WORD_W     = 64;
  localparam int CS_W       = 7;
  localparam int WL_W       = 4;
  localparam int FM_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  // store address as carried through the queue, wide enough for 256 entries
  localparam int ADDR_W     = 8;
  // radix compare width, holds 256
  localparam int RADIX_W    = 9;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

  localparam logic [FM_W-1:0] FILT_ALL      = 2'd0;
  localparam logic [FM_W-1:0] FILT_ADJ      = 2'd1;
  localparam logic [FM_W-1:0] FILT_NO_ADJ   = 2'd2;
  localparam logic [FM_W-1:0] FILT_DISTINCT = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_STEP
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } cmd_entry_t;

endpackage

### rtl/charset_combination_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charset_combination_generator_top: odometer word generator over a charset
// Load, start and step requests in; one result item per step request out.
// ----------------------------------------------------------------------------
// Takes one request item per cycle while the queue has room and gives one word
// per cycle for a run of step requests while out_ready is held high. A step's
// result passes through the command queue, the odometer stage where each
// position reads its own copy of the charset memory, and the filter and result
// register. The charset is held as MAX_LENGTH copies of a MAX_CHARS byte memory,
// all written by each load; entries are undefined until loaded, so load every
// entry below charset_size before stepping. The user writes registers through
// cfg_we/cfg_index/cfg_data only while no step is in flight; the block does not enforce it.
module charset_combination_generator_top #(
  parameter int MAX_CHARS  = ccg_pkg::MAX_CHARS_DEF,
  parameter int MAX_LENGTH = ccg_pkg::MAX_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ccg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ccg_pkg::REQ_W-1:0]        req_type,
  input  logic [ccg_pkg::IDX_W-1:0]        char_index,
  input  logic [ccg_pkg::CHAR_W-1:0]       char_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ccg_pkg::WORD_W-1:0]       word,
  output logic                             passes,
  output logic                             is_last,
  output logic                             exhausted
);

  logic [ccg_pkg::CS_W-1:0] charset_size;
  logic [ccg_pkg::WL_W-1:0] word_length;
  logic [ccg_pkg::FM_W-1:0] filter_mode;
  logic                     q_valid;
  logic                     q_ready;
  ccg_pkg::cmd_entry_t      q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_size <= ccg_pkg::CS_W'(1);
      word_length  <= ccg_pkg::WL_W'(1);
      filter_mode  <= ccg_pkg::FILT_ALL;
    end else if (cfg_we) begin
      case (cfg_index)
        ccg_pkg::CFG_CHARSET_SIZE: charset_size <= cfg_data[ccg_pkg::CS_W-1:0];
        ccg_pkg::CFG_WORD_LENGTH:  word_length  <= cfg_data[ccg_pkg::WL_W-1:0];
        ccg_pkg::CFG_FILTER_MODE:  filter_mode  <= cfg_data[ccg_pkg::FM_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  ccg_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .char_index (char_index),
    .char_value (char_value),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry)
  );

  ccg_back #(
    .MAX_CHARS  (MAX_CHARS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_entry      (q_entry),
    .charset_size (charset_size),
    .word_length  (word_length),
    .filter_mode  (filter_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word         (word),
    .passes       (passes),
    .is_last      (is_last),
    .exhausted    (exhausted)
  );

endmodule

### rtl/ccg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccg_front: request intake and command queue
// Accepts request items, decodes them into commands, drops unknown requests
// and out-of-range loads, and buffers commands in a two-entry queue.
// ----------------------------------------------------------------------------
module ccg_front #(
  parameter int MAX_CHARS = ccg_pkg::MAX_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ccg_pkg::REQ_W-1:0]   req_type,
  input  logic [ccg_pkg::IDX_W-1:0]   char_index,
  input  logic [ccg_pkg::CHAR_W-1:0]  char_value,
  output logic                        q_valid,
  input  logic                        q_ready,
  output ccg_pkg::cmd_entry_t         q_entry
);

  localparam logic [ccg_pkg::RADIX_W-1:0] CHARS_LIM = ccg_pkg::RADIX_W'(MAX_CHARS);

  ccg_pkg::cmd_entry_t             entries [ccg_pkg::QDEPTH];
  logic [ccg_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ccg_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ccg_pkg::QCNT_W-1:0]      count;
  logic                            accept;
  logic                            push;
  logic                            pop;
  ccg_pkg::cmd_entry_t             decoded;
  logic                            in_range;

  assign in_ready = (count != ccg_pkg::QCNT_W'(ccg_pkg::QDEPTH));
  assign accept   = in_valid & in_ready;
  assign q_valid  = (count != '0);
  assign q_entry  = entries[rd_ptr];
  assign pop      = q_valid & q_ready;
  assign in_range = {{(ccg_pkg::RADIX_W - ccg_pkg::IDX_W){1'b0}}, char_index} < CHARS_LIM;

  always_comb begin
    decoded.cmd  = ccg_pkg::CMD_STEP;
    decoded.addr = {{(ccg_pkg::ADDR_W - ccg_pkg::IDX_W){1'b0}}, char_index};
    decoded.data = char_value;
    push         = 1'b0;
    case (req_type)
      ccg_pkg::REQ_LOAD: begin
        decoded.cmd = ccg_pkg::CMD_LOAD;
        push        = accept & in_range;
      end
      ccg_pkg::REQ_START: begin
        decoded.cmd = ccg_pkg::CMD_START;
        push        = accept;
      end
      ccg_pkg::REQ_STEP: begin
        decoded.cmd = ccg_pkg::CMD_STEP;
        push        = accept;
      end
      default: begin
        // drop unknown request
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ccg_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ccg_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + ccg_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - ccg_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/ccg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccg_back: odometer, charset lanes, filter and result register
// Executes queued commands: loads write every position's copy of the charset,
// starts clear the odometer, steps read the word and advance the digits until the run ends.
// ----------------------------------------------------------------------------
module ccg_back #(
  parameter int MAX_CHARS  = ccg_pkg::MAX_CHARS_DEF,
  parameter int MAX_LENGTH = ccg_pkg::MAX_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  ccg_pkg::cmd_entry_t         q_entry,
  input  logic [ccg_pkg::CS_W-1:0]    charset_size,
  input  logic [ccg_pkg::WL_W-1:0]    word_length,
  input  logic [ccg_pkg::FM_W-1:0]    filter_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ccg_pkg::WORD_W-1:0]  word,
  output logic                        passes,
  output logic                        is_last,
  output logic                        exhausted
);

  localparam int DW = $clog2(MAX_CHARS);
  localparam logic [ccg_pkg::RADIX_W-1:0] RADIX_MAX = ccg_pkg::RADIX_W'(MAX_CHARS);
  localparam logic [ccg_pkg::WL_W-1:0]    LEN_MAX   = ccg_pkg::WL_W'(MAX_LENGTH);

  logic [DW-1:0]                   digits      [MAX_LENGTH];
  logic [DW-1:0]                   digits_next [MAX_LENGTH];
  logic                            finished;
  logic                            carry_out;
  logic [ccg_pkg::RADIX_W-1:0]     radix;
  logic [ccg_pkg::WL_W-1:0]        len;

  logic                            fire;
  logic                            step_fire;
  logic                            b_adv;
  logic                            b_can;

  logic                            b_valid;
  logic                            b_exh;
  logic                            b_last;
  logic [ccg_pkg::WL_W-1:0]        b_len;
  logic [ccg_pkg::FM_W-1:0]        b_mode;
  logic [ccg_pkg::CHAR_W-1:0]      b_char [MAX_LENGTH];

  logic [ccg_pkg::WORD_W-1:0]      word_comb;
  logic                            pass_comb;
  logic                            adj;
  logic                            dup;

  // effective radix and length
  always_comb begin
    radix = {{(ccg_pkg::RADIX_W - ccg_pkg::CS_W){1'b0}}, charset_size};
    if (radix == '0) begin
      radix = ccg_pkg::RADIX_W'(1);
    end else if (radix > RADIX_MAX) begin
      radix = RADIX_MAX;
    end
    len = word_length;
    if (len == '0) begin
      len = ccg_pkg::WL_W'(1);
    end else if (len > LEN_MAX) begin
      len = LEN_MAX;
    end
  end

  // odometer advance: ripple the carry from the last active position down
  always_comb begin
    logic carry;
    logic wrap;
    carry = 1'b1;
    wrap  = 1'b0;
    for (int p = MAX_LENGTH - 1; p >= 0; p--) begin
      digits_next[p] = digits[p];
      if (p < int'(len)) begin
        wrap = (ccg_pkg::RADIX_W'(digits[p]) + ccg_pkg::RADIX_W'(1)) >= radix;
        if (carry) begin
          digits_next[p] = wrap ? '0 : digits[p] + DW'(1);
        end
        carry = carry & wrap;
      end
    end
    carry_out = carry;
  end

  assign b_adv     = b_valid & (!out_valid | out_ready);
  assign b_can     = !b_valid | b_adv;
  assign q_ready   = (q_entry.cmd != ccg_pkg::CMD_STEP) | b_can;
  assign fire      = q_valid & q_ready;
  assign step_fire = fire & (q_entry.cmd == ccg_pkg::CMD_STEP);

  // one charset copy per position, so every position reads in the same cycle
  for (genvar lane = 0; lane < MAX_LENGTH; lane++) begin : g_lane
    logic [ccg_pkg::CHAR_W-1:0] store [MAX_CHARS];

    always_ff @(posedge clk) begin
      if (fire && q_entry.cmd == ccg_pkg::CMD_LOAD) begin
        store[q_entry.addr[DW-1:0]] <= q_entry.data;
      end
      if (step_fire) begin
        b_char[lane] <= store[digits[lane]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b0;
      for (int p = 0; p < MAX_LENGTH; p++) begin
        digits[p] <= '0;
      end
    end else if (fire) begin
      case (q_entry.cmd)
        ccg_pkg::CMD_START: begin
          finished <= 1'b0;
          for (int p = 0; p < MAX_LENGTH; p++) begin
            digits[p] <= '0;
          end
        end
        ccg_pkg::CMD_STEP: begin
          if (!finished) begin
            digits <= digits_next;
            if (carry_out) begin
              finished <= 1'b1;
            end
          end
        end
        default: begin
          // loads touch only the charset lanes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (step_fire) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      b_exh  <= finished;
      b_last <= carry_out;
      b_len  <= len;
      b_mode <= filter_mode;
    end
  end

  // word assembly and filter on the read characters
  always_comb begin
    word_comb = '0;
    adj       = 1'b0;
    dup       = 1'b0;
    for (int p = 0; p < MAX_LENGTH; p++) begin
      if (p < int'(b_len)) begin
        word_comb[8*p +: 8] = b_char[p];
      end
    end
    for (int i = 0; i < MAX_LENGTH - 1; i++) begin
      if (i + 1 < int'(b_len) && b_char[i] == b_char[i+1]) begin
        adj = 1'b1;
      end
    end
    for (int i = 0; i < MAX_LENGTH; i++) begin
      for (int k = i + 1; k < MAX_LENGTH; k++) begin
        if (k < int'(b_len) && b_char[i] == b_char[k]) begin
          dup = 1'b1;
        end
      end
    end
    case (b_mode)
      ccg_pkg::FILT_ADJ:      pass_comb = adj;
      ccg_pkg::FILT_NO_ADJ:   pass_comb = !adj;
      ccg_pkg::FILT_DISTINCT: pass_comb = !dup;
      default:                pass_comb = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      word      <= b_exh ? '0 : word_comb;
      passes    <= b_exh ? 1'b0 : pass_comb;
      is_last   <= b_exh ? 1'b0 : b_last;
      exhausted <= b_exh;
    end
  end

endmodule

### rtl/ccg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccg_checker: port-level checks for the charset combination generator
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module ccg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ccg_pkg::WORD_W-1:0]      word,
  input logic                            passes,
  input logic                            is_last,
  input logic                            exhausted
);

  // no result survives a reset
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word) && $stable(passes)
      && $stable(is_last) && $stable(exhausted))
    else $error("stalled result changed");

  // exhausted result carries an empty word and no flags
  a_exhausted_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> word == '0 && !passes && !is_last)
    else $error("exhausted result with payload");

endmodule

bind charset_combination_generator_top ccg_checker u_ccg_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .word      (word),
  .passes    (passes),
  .is_last   (is_last),
  .exhausted (exhausted)
);

### tb/sv/charset_combination_generator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charset_combination_generator_top_test: self-checking odometer bench
// Sends load, start, step and unknown items with random gaps on both channels. Each
// step's word and flags are predicted and compared in order with the output.
// ----------------------------------------------------------------------------
module charset_combination_generator_top_test;
  import ccg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [REQ_W-1:0]     REQ_BOGUS = 2'd3;
  localparam int N_ENTRIES      = MAX_CHARS_DEF;
  localparam int N_POS          = MAX_LENGTH_DEF;
  localparam int ITEM_TARGET    = 500;
  localparam int MAX_GAP        = 18;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_CYCLES   = 200;
  localparam int STALL_STEPS    = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              passes;
    logic              is_last;
    logic              exhausted;
  } word_result_t;

  class odometer_scoreboard;
    logic [CHAR_W-1:0] charset [N_ENTRIES];
    bit                loaded [N_ENTRIES];
    int                digit [N_POS];
    bit                finished;
    logic [CS_W-1:0]   radix_reg;
    logic [WL_W-1:0]   length_reg;
    logic [FM_W-1:0]   filter_reg;
    word_result_t      expected_words [$];
    int                errors;
    int                items_taken;

    function new();
      foreach (loaded[i]) loaded[i] = 0;
      foreach (digit[i]) digit[i] = 0;
      finished = 0;
      radix_reg = 1;
      length_reg = 1;
      filter_reg = FILT_ALL;
      errors = 0;
      items_taken = 0;
    endfunction

    function int radix();
      if (radix_reg == 0) return 1;
      if (radix_reg > N_ENTRIES) return N_ENTRIES;
      return radix_reg;
    endfunction

    function int wlen();
      if (length_reg == 0) return 1;
      if (length_reg > N_POS) return N_POS;
      return length_reg;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHARSET_SIZE: radix_reg = data[CS_W-1:0];
        CFG_WORD_LENGTH:  length_reg = data[WL_W-1:0];
        CFG_FILTER_MODE:  filter_reg = data[FM_W-1:0];
        default: ;
      endcase
    endfunction

    // first never-loaded entry that the next step would read, -1 if none
    function int unloaded_entry();
      int p;
      if (finished) return -1;
      for (p = 0; p < wlen(); p++)
        if (!loaded[digit[p]]) return digit[p];
      return -1;
    endfunction

    function void note_input(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                             logic [CHAR_W-1:0] val);
      word_result_t      r;
      logic [CHAR_W-1:0] c [N_POS];
      int                n, len, p, k;
      bit                carry, adj, dup;
      case (req)
        REQ_LOAD: begin
          charset[idx] = val;
          loaded[idx] = 1;
          items_taken++;
        end
        REQ_START: begin
          foreach (digit[i]) digit[i] = 0;
          finished = 0;
          items_taken++;
        end
        REQ_STEP: begin
          items_taken++;
          if (finished) begin
            r.word = '0;
            r.passes = 0;
            r.is_last = 0;
            r.exhausted = 1;
          end else begin
            n = radix();
            len = wlen();
            r.word = '0;
            adj = 0;
            dup = 0;
            for (p = 0; p < len; p++) begin
              c[p] = charset[digit[p]];
              r.word[CHAR_W*p +: CHAR_W] = c[p];
            end
            // advance from the rightmost position; a digit whose successor reaches the radix wraps
            carry = 1;
            for (p = len - 1; p >= 0 && carry; p--) begin
              if (digit[p] + 1 >= n) digit[p] = 0;
              else begin
                digit[p]++;
                carry = 0;
              end
            end
            if (carry) finished = 1;
            for (p = 0; p < len; p++)
              for (k = p + 1; k < len; k++)
                if (c[p] == c[k]) begin
                  dup = 1;
                  if (k == p + 1) adj = 1;
                end
            case (filter_reg)
              FILT_ADJ:      r.passes = adj;
              FILT_NO_ADJ:   r.passes = !adj;
              FILT_DISTINCT: r.passes = !dup;
              default:       r.passes = 1;
            endcase
            r.is_last = carry;
            r.exhausted = 0;
          end
          expected_words.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      errors++;
      $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
    endtask

    task check_result(word_result_t got);
      word_result_t want;
      if (expected_words.size() == 0) begin
        report("unexpected result", got.word, '0);
        return;
      end
      want = expected_words.pop_front();
      if (got.word !== want.word) report("word", got.word, want.word);
      if (got.passes !== want.passes) report("passes", got.passes, want.passes);
      if (got.is_last !== want.is_last) report("is_last", got.is_last, want.is_last);
      if (got.exhausted !== want.exhausted)
        report("exhausted", got.exhausted, want.exhausted);
    endtask
  endclass

  logic                  clk, rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid, in_ready;
  logic [REQ_W-1:0]      req_type;
  logic [IDX_W-1:0]      char_index;
  logic [CHAR_W-1:0]     char_value;
  logic                  out_valid, out_ready;
  logic [WORD_W-1:0]     word;
  logic                  passes, is_last, exhausted;

  odometer_scoreboard board;
  bit hold_output, send_fast, recv_fast;
  int idle_cycles;

  charset_combination_generator_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .char_index (char_index),
    .char_value (char_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word       (word),
    .passes     (passes),
    .is_last    (is_last),
    .exhausted  (exhausted)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("charset_combination_generator_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                      logic [CHAR_W-1:0] val);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= req;
    char_index <= idx;
    char_value <= val;
    do @(posedge clk); while (!in_ready);
    board.note_input(req, idx, val);
  endtask

  // load whatever the next step would read before sending it
  task automatic step_word();
    while (board.unloaded_entry() >= 0)
      send(REQ_LOAD, board.unloaded_entry(), $urandom_range(0, 255));
    send(REQ_STEP, $urandom, $urandom);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // drain the block, then write every register
  task automatic write_regs(int cs, int wl, int fm);
    in_valid <= 0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(CFG_CHARSET_SIZE, cs);
    reg_write(CFG_WORD_LENGTH, wl);
    reg_write(CFG_FILTER_MODE, ($urandom_range(0, 31) << FM_W) | fm);
    reg_write(CFG_SPARE, $urandom);
    cfg_we <= 0;
  endtask

  task automatic run_phase(bit force_stall);
    int cs, wl, fm, steps, total, i;
    bit narrow;
    case ($urandom_range(0, 9))
      0:       cs = 0;
      1:       cs = N_ENTRIES;
      2:       cs = $urandom_range(N_ENTRIES + 1, 127);
      default: cs = $urandom_range(1, 5);
    endcase
    case ($urandom_range(0, 9))
      0:       wl = 0;
      1:       wl = N_POS;
      2:       wl = $urandom_range(N_POS + 1, 127);
      default: wl = $urandom_range(1, 4);
    endcase
    fm = $urandom_range(0, 3);
    write_regs(cs, wl, fm);
    send_fast = ($urandom_range(0, 3) == 0);
    narrow = $urandom_range(0, 1);
    for (i = 0; i < board.radix(); i++)
      send(REQ_LOAD, i, narrow ? $urandom_range(0, 3) : $urandom_range(0, 255));
    // now and then keep the old digits so the new settings apply mid-run
    if ($urandom_range(0, 3) != 0) send(REQ_START, $urandom, $urandom);
    if (force_stall || $urandom_range(0, 5) == 0) begin
      hold_output = 1;
      send_fast = 1;
    end
    steps = $urandom_range(4, 40);
    total = 1;
    for (i = 0; i < board.wlen() && total <= 60; i++) total *= board.radix();
    if (total <= 60 && $urandom_range(0, 1)) steps = total + $urandom_range(1, 3);
    // enough steps to fill the block while the output is held
    if (force_stall && steps < STALL_STEPS) steps = STALL_STEPS;
    for (i = 0; i < steps; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       send(REQ_LOAD, $urandom, $urandom);
          1:       send(REQ_BOGUS, $urandom, $urandom);
          default: send(REQ_START, $urandom, $urandom);
        endcase
      end else begin
        step_word();
      end
    end
  endtask

  initial begin : result_side
    int gap;
    word_result_t got;
    out_ready <= 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_output) begin
        gap = STALL_CYCLES;
        hold_output = 0;
      end else begin
        gap = recv_fast ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got.word = word;
      got.passes = passes;
      got.is_last = is_last;
      got.exhausted = exhausted;
      board.check_result(got);
      if ($urandom_range(0, 15) == 0) recv_fast = !recv_fast;
    end
  end

  initial begin : request_side
    int phase;
    board = new();
    hold_output = 0;
    send_fast = 0;
    recv_fast = 0;
    idle_cycles <= 0;
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= CFG_CHARSET_SIZE;
    cfg_data <= '0;
    in_valid <= 0;
    req_type <= REQ_LOAD;
    char_index <= '0;
    char_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // one position, one character: a single word, then exhausted
    send(REQ_LOAD, 0, 8'hFF);
    send(REQ_LOAD, N_ENTRIES - 1, 8'h00);
    send(REQ_BOGUS, 6'h3F, 8'hFF);
    step_word();
    step_word();
    send(REQ_START, 0, 0);
    step_word();
    // full length, two characters
    write_regs(2, N_POS, FILT_ADJ);
    send(REQ_LOAD, 1, 8'h00);
    send(REQ_START, 6'h3F, 8'hFF);
    repeat (3) step_word();
    // drop the radix under the live digits
    write_regs(1, N_POS, FILT_NO_ADJ);
    repeat (2) step_word();
    write_regs(0, 0, FILT_DISTINCT);
    repeat (2) step_word();
    write_regs(127, 15, FILT_ALL);
    repeat (2) step_word();

    phase = 0;
    while (board.items_taken < ITEM_TARGET) begin
      run_phase(phase == 0);
      phase++;
    end

    in_valid <= 0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("charset_combination_generator_top_test OK");
    else $display("charset_combination_generator_top_test NOT OK");
    $finish;
  end
endmodule

### filelist.f
rtl/ccg_pkg.sv
rtl/ccg_front.sv
rtl/ccg_back.sv
rtl/charset_combination_generator_top.sv
rtl/ccg_checker.sv
tb/sv/charset_combination_generator_top_test.sv
